FILE: design/hlfr_pkg.sv
// Shared types, operation codes and saturation helpers for the HI/LO and FP
// register transfer unit. No dependencies; the top level, hlfr_exec and hlfr_checker import it.
package hlfr_pkg;

   localparam int unsigned OpW   = 5;
   localparam int unsigned RegW  = 5;
   localparam int unsigned DwW   = 64;
   localparam int unsigned FpW   = 32;
   localparam int unsigned FpDep = 32;
   localparam int unsigned CsrAw = 3;
   localparam int unsigned CsrDw = 32;

   // Operation codes
   localparam logic [OpW-1:0] OP_MFHI  = 5'd0;
   localparam logic [OpW-1:0] OP_MFLO  = 5'd1;
   localparam logic [OpW-1:0] OP_MOVN  = 5'd2;
   localparam logic [OpW-1:0] OP_MOVZ  = 5'd3;
   localparam logic [OpW-1:0] OP_MTHI  = 5'd4;
   localparam logic [OpW-1:0] OP_MTLO  = 5'd5;
   localparam logic [OpW-1:0] OP_MFHI1 = 5'd6;
   localparam logic [OpW-1:0] OP_MFLO1 = 5'd7;
   localparam logic [OpW-1:0] OP_MTHI1 = 5'd8;
   localparam logic [OpW-1:0] OP_MTLO1 = 5'd9;
   localparam logic [OpW-1:0] OP_PMFHI = 5'd10;
   localparam logic [OpW-1:0] OP_PMFHL = 5'd11;
   localparam logic [OpW-1:0] OP_PMFLO = 5'd12;
   localparam logic [OpW-1:0] OP_PMTHI = 5'd13;
   localparam logic [OpW-1:0] OP_PMTHL = 5'd14;
   localparam logic [OpW-1:0] OP_PMTLO = 5'd15;
   localparam logic [OpW-1:0] OP_MFC1  = 5'd16;
   localparam logic [OpW-1:0] OP_MOVS  = 5'd17;
   localparam logic [OpW-1:0] OP_MTC1  = 5'd18;

   // PMFHL / PMTHL modes
   localparam logic [RegW-1:0] MODE_LW  = 5'd0;
   localparam logic [RegW-1:0] MODE_UW  = 5'd1;
   localparam logic [RegW-1:0] MODE_SLW = 5'd2;
   localparam logic [RegW-1:0] MODE_LH  = 5'd3;
   localparam logic [RegW-1:0] MODE_SH  = 5'd4;

   // Register indexes of the CSR port
   localparam logic [0:0] CSR_COP1_USABLE = 1'b0;

   // General-register writeback of one item
   typedef struct packed {
      logic            wr_low;
      logic            wr_high;
      logic [RegW-1:0] dest;
      logic [DwW-1:0]  val_low;
      logic [DwW-1:0]  val_high;
      logic            unusable;
   } hlfr_rsp_type;

   // State updates caused by one item
   typedef struct packed {
      logic [1:0]      hi_we;
      logic [1:0]      lo_we;
      logic [DwW-1:0]  hi0;
      logic [DwW-1:0]  hi1;
      logic [DwW-1:0]  lo0;
      logic [DwW-1:0]  lo1;
      logic            fp_we;
      logic [RegW-1:0] fp_addr;
      logic [FpW-1:0]  fp_data;
   } hlfr_upd_type;

   // Signed word saturated to a signed halfword
   function automatic logic [15:0] sat_half(input logic [31:0] w);
      logic same;
      same = (w[31:15] == {17{w[31]}});
      if (same) begin
         return w[15:0];
      end
      return w[31] ? 16'h8000 : 16'h7fff;
   endfunction

   // Signed h:l saturated to a signed word, sign-extended to a dword
   function automatic logic [63:0] sat_word(input logic [31:0] h, input logic [31:0] l);
      logic same;
      same = ({h, l[31]} == {33{h[31]}});
      if (same) begin
         return {{32{l[31]}}, l};
      end
      return h[31] ? 64'hffff_ffff_8000_0000 : 64'h0000_0000_7fff_ffff;
   endfunction

endpackage

FILE: design/hilo_fpr_register_transfer_unit.sv
// Top level of the HI/LO and FP register transfer unit: FP register RAM with
// forwarding, HI/LO registers, execute stage and output register.
// Depends on hlfr_pkg, hlfr_ram and hlfr_exec.
//
//   channel | direction | handshake           | carries
//   req_    | in        | req_valid/req_stall | op, register fields, rs/rt values
//   rsp_    | out       | rsp_valid/rsp_stall | GPR writeback and cop1 flag
//   csr_    | in/out    | APB psel/penable    | cop1_usable at address 0
//
// One item per cycle while rsp_stall is low; the FP RAM read at rd and the capture
// into execute share the accept edge, execute then loads the output register, and
// rsp_valid and the result come straight from the output register.
// A FP write still in execute is forwarded to a read of the same entry.
// Reset clears HI/LO, the FP valid bits and sets cop1_usable; no clearing pass.
// With the output register full and rsp_stall high, execute holds and req_stall
// rises while an item sits in execute.
module hilo_fpr_register_transfer_unit (
   input  logic                       clock,
   input  logic                       reset,
   // Input channel
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [hlfr_pkg::OpW-1:0]   req_op,
   input  logic [hlfr_pkg::RegW-1:0]  req_rd_field,
   input  logic [hlfr_pkg::RegW-1:0]  req_rt_field,
   input  logic [hlfr_pkg::RegW-1:0]  req_sa_field,
   input  logic [hlfr_pkg::DwW-1:0]   req_rs_value_low,
   input  logic [hlfr_pkg::DwW-1:0]   req_rs_value_high,
   input  logic [hlfr_pkg::DwW-1:0]   req_rt_value_low,
   // Result channel
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_gpr_write_low,
   output logic                       rsp_gpr_write_high,
   output logic [hlfr_pkg::RegW-1:0]  rsp_gpr_dest,
   output logic [hlfr_pkg::DwW-1:0]   rsp_gpr_value_low,
   output logic [hlfr_pkg::DwW-1:0]   rsp_gpr_value_high,
   output logic                       rsp_cop1_unusable,
   // Configuration port
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [hlfr_pkg::CsrAw-1:0] csr_paddr,
   input  logic [hlfr_pkg::CsrDw-1:0] csr_pwdata,
   output logic [hlfr_pkg::CsrDw-1:0] csr_prdata,
   output logic                       csr_pready
);
   import hlfr_pkg::*;

   logic            cop1_usable_ff;
   logic            csr_sel_usable;

   logic            s1_valid_ff;
   logic [OpW-1:0]  s1_op_ff;
   logic [RegW-1:0] s1_rd_ff;
   logic [RegW-1:0] s1_rt_ff;
   logic [RegW-1:0] s1_sa_ff;
   logic [DwW-1:0]  s1_rs_low_ff;
   logic [DwW-1:0]  s1_rs_high_ff;
   logic [DwW-1:0]  s1_rt_low_ff;
   logic            s1_go;
   logic            commit;
   logic            accept;

   logic [DwW-1:0]  hi0_ff;
   logic [DwW-1:0]  hi1_ff;
   logic [DwW-1:0]  lo0_ff;
   logic [DwW-1:0]  lo1_ff;

   logic [FpDep-1:0] fp_valid_ff;
   logic             rd_valid_ff;
   logic             fwd_hit_ff;
   logic [FpW-1:0]   fwd_data_ff;
   logic [FpW-1:0]   ram_rdata;
   logic [FpW-1:0]   fp_src;
   logic             fp_we;

   hlfr_rsp_type    exe_rsp;
   hlfr_upd_type    exe_upd;
   hlfr_rsp_type    out_ff;
   logic            out_valid_ff;
   logic            out_valid_in;
   logic            s1_valid_in;

   // CSR port: always ready, one register
   assign csr_pready     = 1'b1;
   assign csr_sel_usable = (csr_paddr[CsrAw-1] == CSR_COP1_USABLE);
   assign csr_prdata     = csr_sel_usable ? {{(CsrDw-1){1'b0}}, cop1_usable_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         cop1_usable_ff <= 1'b1;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_sel_usable) begin
         cop1_usable_ff <= csr_pwdata[0];
      end
   end

   // Handshake: execute advances when the output register is free or drains
   assign s1_go     = !out_valid_ff || !rsp_stall;
   assign commit    = s1_valid_ff && s1_go;
   assign req_stall = s1_valid_ff && !s1_go;
   assign accept    = req_valid && !req_stall;

   assign s1_valid_in  = accept ? 1'b1 : (commit ? 1'b0 : s1_valid_ff);
   assign out_valid_in = commit ? 1'b1 : ((out_valid_ff && !rsp_stall) ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture the item into execute
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff      <= req_op;
         s1_rd_ff      <= req_rd_field;
         s1_rt_ff      <= req_rt_field;
         s1_sa_ff      <= req_sa_field;
         s1_rs_low_ff  <= req_rs_value_low;
         s1_rs_high_ff <= req_rs_value_high;
         s1_rt_low_ff  <= req_rt_value_low;
      end
   end

   // FP register file
   assign fp_we = commit && exe_upd.fp_we;

   hlfr_ram #(
      .WIDTH (FpW),
      .DEPTH (FpDep)
   ) u_fp_ram (
      .clock   (clock),
      .wr_en   (fp_we),
      .wr_addr (exe_upd.fp_addr),
      .wr_data (exe_upd.fp_data),
      .rd_en   (accept),
      .rd_addr (req_rd_field),
      .rd_data (ram_rdata)
   );

   // Valid bits: unwritten entries read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         fp_valid_ff <= '0;
      end else if (fp_we) begin
         fp_valid_ff[exe_upd.fp_addr] <= 1'b1;
      end
   end

   // Forward a write that lands in the same cycle as the read
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_valid_ff <= fp_valid_ff[req_rd_field];
         fwd_hit_ff  <= fp_we && (exe_upd.fp_addr == req_rd_field);
         fwd_data_ff <= exe_upd.fp_data;
      end
   end

   assign fp_src = fwd_hit_ff ? fwd_data_ff : (rd_valid_ff ? ram_rdata : '0);

   hlfr_exec u_exec (
      .op            (s1_op_ff),
      .rd_field      (s1_rd_ff),
      .rt_field      (s1_rt_ff),
      .sa_field      (s1_sa_ff),
      .rs_value_low  (s1_rs_low_ff),
      .rs_value_high (s1_rs_high_ff),
      .rt_value_low  (s1_rt_low_ff),
      .hi0           (hi0_ff),
      .hi1           (hi1_ff),
      .lo0           (lo0_ff),
      .lo1           (lo1_ff),
      .fp_src        (fp_src),
      .cop1_usable   (cop1_usable_ff),
      .rsp           (exe_rsp),
      .upd           (exe_upd)
   );

   // HI/LO dwords update on commit
   always_ff @(posedge clock) begin
      if (reset) begin
         hi0_ff <= '0;
         hi1_ff <= '0;
         lo0_ff <= '0;
         lo1_ff <= '0;
      end else if (commit) begin
         if (exe_upd.hi_we[0]) hi0_ff <= exe_upd.hi0;
         if (exe_upd.hi_we[1]) hi1_ff <= exe_upd.hi1;
         if (exe_upd.lo_we[0]) lo0_ff <= exe_upd.lo0;
         if (exe_upd.lo_we[1]) lo1_ff <= exe_upd.lo1;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (commit) begin
         out_ff <= exe_rsp;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_gpr_write_low  = out_ff.wr_low;
   assign rsp_gpr_write_high = out_ff.wr_high;
   assign rsp_gpr_dest       = out_ff.dest;
   assign rsp_gpr_value_low  = out_ff.val_low;
   assign rsp_gpr_value_high = out_ff.val_high;
   assign rsp_cop1_unusable  = out_ff.unusable;

endmodule

FILE: design/hlfr_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// Standalone; no package dependency.
module hlfr_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read, hold when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/hlfr_exec.sv
// Execute stage: decodes one transfer item and forms its writeback and the
// HI/LO/FP state updates. Combinational; depends on hlfr_pkg.
module hlfr_exec (
   input  logic [hlfr_pkg::OpW-1:0]  op,
   input  logic [hlfr_pkg::RegW-1:0] rd_field,
   input  logic [hlfr_pkg::RegW-1:0] rt_field,
   input  logic [hlfr_pkg::RegW-1:0] sa_field,
   input  logic [hlfr_pkg::DwW-1:0]  rs_value_low,
   input  logic [hlfr_pkg::DwW-1:0]  rs_value_high,
   input  logic [hlfr_pkg::DwW-1:0]  rt_value_low,
   input  logic [hlfr_pkg::DwW-1:0]  hi0,
   input  logic [hlfr_pkg::DwW-1:0]  hi1,
   input  logic [hlfr_pkg::DwW-1:0]  lo0,
   input  logic [hlfr_pkg::DwW-1:0]  lo1,
   input  logic [hlfr_pkg::FpW-1:0]  fp_src,
   input  logic                      cop1_usable,
   output hlfr_pkg::hlfr_rsp_type    rsp,
   output hlfr_pkg::hlfr_upd_type    upd
);
   import hlfr_pkg::*;

   logic [DwW-1:0] fh_low;
   logic [DwW-1:0] fh_high;
   logic           fh_ok;

   // PMFHL formatting by mode
   always_comb begin
      fh_low  = '0;
      fh_high = '0;
      fh_ok   = 1'b1;
      unique case (sa_field)
         MODE_LW: begin
            fh_low  = {hi0[31:0], lo0[31:0]};
            fh_high = {hi1[31:0], lo1[31:0]};
         end
         MODE_UW: begin
            fh_low  = {hi0[63:32], lo0[63:32]};
            fh_high = {hi1[63:32], lo1[63:32]};
         end
         MODE_SLW: begin
            fh_low  = sat_word(hi0[31:0], lo0[31:0]);
            fh_high = sat_word(hi1[31:0], lo1[31:0]);
         end
         MODE_LH: begin
            fh_low  = {hi0[47:32], hi0[15:0], lo0[47:32], lo0[15:0]};
            fh_high = {hi1[47:32], hi1[15:0], lo1[47:32], lo1[15:0]};
         end
         MODE_SH: begin
            fh_low  = {sat_half(hi0[63:32]), sat_half(hi0[31:0]),
                       sat_half(lo0[63:32]), sat_half(lo0[31:0])};
            fh_high = {sat_half(hi1[63:32]), sat_half(hi1[31:0]),
                       sat_half(lo1[63:32]), sat_half(lo1[31:0])};
         end
         default: fh_ok = 1'b0;
      endcase
   end

   // Decode; anything without a writeback leaves dest and values zero
   always_comb begin
      rsp         = '0;
      upd         = '0;
      upd.hi0     = hi0;
      upd.hi1     = hi1;
      upd.lo0     = lo0;
      upd.lo1     = lo1;
      upd.fp_addr = rd_field;
      upd.fp_data = rt_value_low[FpW-1:0];
      unique case (op)
         OP_MFHI, OP_MFLO, OP_MFHI1, OP_MFLO1: begin
            rsp.wr_low = 1'b1;
            rsp.dest   = rd_field;
            unique case (op)
               OP_MFHI:  rsp.val_low = hi0;
               OP_MFLO:  rsp.val_low = lo0;
               OP_MFHI1: rsp.val_low = hi1;
               default:  rsp.val_low = lo1;
            endcase
         end
         OP_MOVN, OP_MOVZ: begin
            if ((rt_value_low != '0) == (op == OP_MOVN)) begin
               rsp.wr_low  = 1'b1;
               rsp.dest    = rd_field;
               rsp.val_low = rs_value_low;
            end
         end
         OP_MTHI: begin
            upd.hi_we[0] = 1'b1;
            upd.hi0      = rs_value_low;
         end
         OP_MTLO: begin
            upd.lo_we[0] = 1'b1;
            upd.lo0      = rs_value_low;
         end
         OP_MTHI1: begin
            upd.hi_we[1] = 1'b1;
            upd.hi1      = rs_value_low;
         end
         OP_MTLO1: begin
            upd.lo_we[1] = 1'b1;
            upd.lo1      = rs_value_low;
         end
         OP_PMFHI, OP_PMFLO: begin
            rsp.wr_low   = 1'b1;
            rsp.wr_high  = 1'b1;
            rsp.dest     = rd_field;
            rsp.val_low  = (op == OP_PMFHI) ? hi0 : lo0;
            rsp.val_high = (op == OP_PMFHI) ? hi1 : lo1;
         end
         OP_PMFHL: begin
            if (fh_ok) begin
               rsp.wr_low   = 1'b1;
               rsp.wr_high  = 1'b1;
               rsp.dest     = rd_field;
               rsp.val_low  = fh_low;
               rsp.val_high = fh_high;
            end
         end
         OP_PMTHI: begin
            upd.hi_we = 2'b11;
            upd.hi0   = rs_value_low;
            upd.hi1   = rs_value_high;
         end
         OP_PMTLO: begin
            upd.lo_we = 2'b11;
            upd.lo0   = rs_value_low;
            upd.lo1   = rs_value_high;
         end
         OP_PMTHL: begin
            // Word mode only: even words load, odd words keep
            if (sa_field == MODE_LW) begin
               upd.hi_we = 2'b11;
               upd.lo_we = 2'b11;
               upd.lo0   = {lo0[63:32], rs_value_low[31:0]};
               upd.hi0   = {hi0[63:32], rs_value_low[63:32]};
               upd.lo1   = {lo1[63:32], rs_value_high[31:0]};
               upd.hi1   = {hi1[63:32], rs_value_high[63:32]};
            end
         end
         OP_MFC1: begin
            if (!cop1_usable) begin
               rsp.unusable = 1'b1;
            end else begin
               rsp.wr_low   = 1'b1;
               rsp.wr_high  = 1'b1;
               rsp.dest     = rt_field;
               rsp.val_low  = {{32{fp_src[31]}}, fp_src};
               rsp.val_high = {DwW{fp_src[31]}};
            end
         end
         OP_MOVS: begin
            if (!cop1_usable) begin
               rsp.unusable = 1'b1;
            end else begin
               upd.fp_we   = 1'b1;
               upd.fp_addr = sa_field;
               upd.fp_data = fp_src;
            end
         end
         OP_MTC1: begin
            if (!cop1_usable) begin
               rsp.unusable = 1'b1;
            end else begin
               upd.fp_we = 1'b1;
            end
         end
         default: ;
      endcase
   end

endmodule

FILE: design/hlfr_checker.sv
// Port-level checker for the HI/LO and FP register transfer unit, bound to the
// top level. Depends on hlfr_pkg for widths.
module hlfr_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  logic                      rsp_gpr_write_low,
   input  logic                      rsp_gpr_write_high,
   input  logic [hlfr_pkg::RegW-1:0] rsp_gpr_dest,
   input  logic [hlfr_pkg::DwW-1:0]  rsp_gpr_value_low,
   input  logic [hlfr_pkg::DwW-1:0]  rsp_gpr_value_high,
   input  logic                      rsp_cop1_unusable
);
   import hlfr_pkg::*;

   // An item without writeback carries an all-zero payload
   a_no_write_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_gpr_write_low && !rsp_gpr_write_high
      |-> rsp_gpr_dest == '0 && rsp_gpr_value_low == '0 && rsp_gpr_value_high == '0)
      else $error("writeback-free item has nonzero payload");

   // A refused FP transfer writes nothing
   a_unusable_no_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_cop1_unusable |-> !rsp_gpr_write_low && !rsp_gpr_write_high)
      else $error("refused item writes a register");

   // The upper dword is never written alone
   a_high_implies_low: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_gpr_write_high |-> rsp_gpr_write_low)
      else $error("upper dword written without lower dword");

   // A stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_gpr_value_low)
         && $stable(rsp_gpr_dest))
      else $error("stalled item changed");

   // Nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("item valid after reset");

endmodule

bind hilo_fpr_register_transfer_unit hlfr_checker u_hlfr_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_gpr_write_low  (rsp_gpr_write_low),
   .rsp_gpr_write_high (rsp_gpr_write_high),
   .rsp_gpr_dest       (rsp_gpr_dest),
   .rsp_gpr_value_low  (rsp_gpr_value_low),
   .rsp_gpr_value_high (rsp_gpr_value_high),
   .rsp_cop1_unusable  (rsp_cop1_unusable)
);

FILE: bench/tb.sv
// Self-checking bench for the HI/LO and FP register transfer unit: a queue-fed
// driver, a checking monitor and an APB task for cop1_usable.
// Depends on hlfr_pkg and the hilo_fpr_register_transfer_unit top level.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import hlfr_pkg::*;

   localparam int unsigned LongHoldAt  = 400;
   localparam int unsigned LongHoldLen = 300;
   localparam int unsigned PhaseLen    = 250;
   localparam int unsigned MaxPrints   = 40;

   // One instruction as it is offered on the input channel
   typedef struct packed {
      logic [OpW-1:0]  op;
      logic [RegW-1:0] rd;
      logic [RegW-1:0] rt;
      logic [RegW-1:0] sa;
      logic [DwW-1:0]  rs_lo;
      logic [DwW-1:0]  rs_hi;
      logic [DwW-1:0]  rt_lo;
   } xfer_item_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [OpW-1:0]     req_op = '0;
   logic [RegW-1:0]    req_rd_field = '0;
   logic [RegW-1:0]    req_rt_field = '0;
   logic [RegW-1:0]    req_sa_field = '0;
   logic [DwW-1:0]     req_rs_value_low = '0;
   logic [DwW-1:0]     req_rs_value_high = '0;
   logic [DwW-1:0]     req_rt_value_low = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_gpr_write_low;
   logic               rsp_gpr_write_high;
   logic [RegW-1:0]    rsp_gpr_dest;
   logic [DwW-1:0]     rsp_gpr_value_low;
   logic [DwW-1:0]     rsp_gpr_value_high;
   logic               rsp_cop1_unusable;
   logic               csr_psel = 1'b0;
   logic               csr_penable = 1'b0;
   logic               csr_pwrite = 1'b0;
   logic [CsrAw-1:0]   csr_paddr = '0;
   logic [CsrDw-1:0]   csr_pwdata = '0;
   logic [CsrDw-1:0]   csr_prdata;
   logic               csr_pready;

   // Shadow copy of the block's architectural state
   logic [DwW-1:0]     hi_shadow [2];
   logic [DwW-1:0]     lo_shadow [2];
   logic [FpW-1:0]     fpr_shadow [FpDep];
   logic               cop1_on;

   xfer_item_type      instr_queue [$];
   hlfr_rsp_type       writeback_queue [$];
   xfer_item_type      on_bus;
   int unsigned        send_gap = 0;
   int unsigned        stall_left = 0;
   int unsigned        issued = 0;
   int unsigned        retired = 0;
   int unsigned        mismatches = 0;
   bit                 idle_enable = 1'b0;
   bit                 long_hold_done = 1'b0;

   hilo_fpr_register_transfer_unit u_top (.*);

   always #5 clock = ~clock;

   // Signed word clamped to a signed halfword
   function automatic logic [15:0] clamp_half(input logic [31:0] w);
      int signed s;
      s = signed'(w);
      if (s > 32767) return 16'h7fff;
      if (s < -32768) return 16'h8000;
      return w[15:0];
   endfunction

   // Signed h:l clamped to a signed word and widened to a dword
   function automatic logic [63:0] clamp_word(input logic [31:0] h, input logic [31:0] l);
      longint signed v;
      v = signed'({h, l});
      if (v > 64'sd2147483647) return 64'h0000_0000_7fff_ffff;
      if (v < -64'sd2147483648) return 64'hffff_ffff_8000_0000;
      return v;
   endfunction

   // Run one instruction on the shadow state and return its writeback
   function automatic hlfr_rsp_type execute_transfer(input xfer_item_type it);
      hlfr_rsp_type r;
      logic [FpW-1:0] f;
      r = '0;
      r.dest = it.rd;
      case (it.op)
         OP_MFHI:  begin r.wr_low = 1'b1; r.val_low = hi_shadow[0]; end
         OP_MFLO:  begin r.wr_low = 1'b1; r.val_low = lo_shadow[0]; end
         OP_MFHI1: begin r.wr_low = 1'b1; r.val_low = hi_shadow[1]; end
         OP_MFLO1: begin r.wr_low = 1'b1; r.val_low = lo_shadow[1]; end
         OP_MOVN: begin
            if (it.rt_lo != '0) begin r.wr_low = 1'b1; r.val_low = it.rs_lo; end
         end
         OP_MOVZ: begin
            if (it.rt_lo == '0) begin r.wr_low = 1'b1; r.val_low = it.rs_lo; end
         end
         OP_MTHI:  hi_shadow[0] = it.rs_lo;
         OP_MTLO:  lo_shadow[0] = it.rs_lo;
         OP_MTHI1: hi_shadow[1] = it.rs_lo;
         OP_MTLO1: lo_shadow[1] = it.rs_lo;
         OP_PMFHI: begin
            r.wr_low = 1'b1; r.wr_high = 1'b1;
            r.val_low = hi_shadow[0]; r.val_high = hi_shadow[1];
         end
         OP_PMFLO: begin
            r.wr_low = 1'b1; r.wr_high = 1'b1;
            r.val_low = lo_shadow[0]; r.val_high = lo_shadow[1];
         end
         OP_PMFHL: begin
            r.wr_low = 1'b1; r.wr_high = 1'b1;
            case (it.sa)
               MODE_LW: begin
                  r.val_low  = {hi_shadow[0][31:0], lo_shadow[0][31:0]};
                  r.val_high = {hi_shadow[1][31:0], lo_shadow[1][31:0]};
               end
               MODE_UW: begin
                  r.val_low  = {hi_shadow[0][63:32], lo_shadow[0][63:32]};
                  r.val_high = {hi_shadow[1][63:32], lo_shadow[1][63:32]};
               end
               MODE_SLW: begin
                  r.val_low  = clamp_word(hi_shadow[0][31:0], lo_shadow[0][31:0]);
                  r.val_high = clamp_word(hi_shadow[1][31:0], lo_shadow[1][31:0]);
               end
               MODE_LH: begin
                  r.val_low  = {hi_shadow[0][47:32], hi_shadow[0][15:0],
                                lo_shadow[0][47:32], lo_shadow[0][15:0]};
                  r.val_high = {hi_shadow[1][47:32], hi_shadow[1][15:0],
                                lo_shadow[1][47:32], lo_shadow[1][15:0]};
               end
               MODE_SH: begin
                  r.val_low  = {clamp_half(hi_shadow[0][63:32]),
                                clamp_half(hi_shadow[0][31:0]),
                                clamp_half(lo_shadow[0][63:32]),
                                clamp_half(lo_shadow[0][31:0])};
                  r.val_high = {clamp_half(hi_shadow[1][63:32]),
                                clamp_half(hi_shadow[1][31:0]),
                                clamp_half(lo_shadow[1][63:32]),
                                clamp_half(lo_shadow[1][31:0])};
               end
               default: begin r.wr_low = 1'b0; r.wr_high = 1'b0; end
            endcase
         end
         OP_PMTHI: begin hi_shadow[0] = it.rs_lo; hi_shadow[1] = it.rs_hi; end
         OP_PMTLO: begin lo_shadow[0] = it.rs_lo; lo_shadow[1] = it.rs_hi; end
         OP_PMTHL: begin
            if (it.sa == MODE_LW) begin
               lo_shadow[0][31:0] = it.rs_lo[31:0];
               hi_shadow[0][31:0] = it.rs_lo[63:32];
               lo_shadow[1][31:0] = it.rs_hi[31:0];
               hi_shadow[1][31:0] = it.rs_hi[63:32];
            end
         end
         OP_MFC1: begin
            if (!cop1_on) begin
               r.unusable = 1'b1;
            end else begin
               f = fpr_shadow[it.rd];
               r.dest = it.rt;
               r.wr_low = 1'b1; r.wr_high = 1'b1;
               r.val_low = {{32{f[31]}}, f};
               r.val_high = {64{f[31]}};
            end
         end
         OP_MOVS: begin
            if (!cop1_on) r.unusable = 1'b1;
            else fpr_shadow[it.sa] = fpr_shadow[it.rd];
         end
         OP_MTC1: begin
            if (!cop1_on) r.unusable = 1'b1;
            else fpr_shadow[it.rd] = it.rt_lo[31:0];
         end
         default: ;
      endcase
      // no writeback: zero the whole destination side
      if (!r.wr_low && !r.wr_high) begin
         r.dest = '0; r.val_low = '0; r.val_high = '0;
      end
      return r;
   endfunction

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= MaxPrints)
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
      end
   endtask

   // Driver: predict on accept, then hold, idle or offer the next item
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            writeback_queue.push_back(execute_transfer(on_bus));
            issued++;
         end
         if (req_valid && req_stall) begin
            req_valid <= 1'b1;
         end else if (send_gap != 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (instr_queue.size() != 0) begin
            if (idle_enable && $urandom_range(0, 9) == 0) begin
               send_gap <= $urandom_range(0, 15);
               req_valid <= 1'b0;
            end else begin
               on_bus = instr_queue.pop_front();
               req_op <= on_bus.op;
               req_rd_field <= on_bus.rd;
               req_rt_field <= on_bus.rt;
               req_sa_field <= on_bus.sa;
               req_rs_value_low <= on_bus.rs_lo;
               req_rs_value_high <= on_bus.rs_hi;
               req_rt_value_low <= on_bus.rt_lo;
               req_valid <= 1'b1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: compare each writeback, then pick the next stall state
   always @(posedge clock) begin
      hlfr_rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (writeback_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= MaxPrints)
                  $display("%0t: writeback expected none, got dest %0d low %h high %h",
                           $time, rsp_gpr_dest, rsp_gpr_value_low, rsp_gpr_value_high);
            end else begin
               want = writeback_queue.pop_front();
               check_field("gpr_write_low", want.wr_low, rsp_gpr_write_low);
               check_field("gpr_write_high", want.wr_high, rsp_gpr_write_high);
               check_field("gpr_dest", want.dest, rsp_gpr_dest);
               check_field("gpr_value_low", want.val_low, rsp_gpr_value_low);
               check_field("gpr_value_high", want.val_high, rsp_gpr_value_high);
               check_field("cop1_unusable", want.unusable, rsp_cop1_unusable);
            end
            retired++;
         end
         // one long hold so the block backs up into its input, plus random stalls while idle_enable is set
         if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            rsp_stall <= 1'b1;
         end else if (retired >= LongHoldAt && !long_hold_done) begin
            long_hold_done = 1'b1;
            stall_left <= LongHoldLen;
            rsp_stall <= 1'b1;
         end else if (idle_enable && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 15);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic queue_instr(input logic [OpW-1:0] op, input logic [RegW-1:0] rd,
                              input logic [RegW-1:0] rt, input logic [RegW-1:0] sa,
                              input logic [DwW-1:0] rs_lo, input logic [DwW-1:0] rs_hi,
                              input logic [DwW-1:0] rt_lo);
      instr_queue.push_back(xfer_item_type'{op, rd, rt, sa, rs_lo, rs_hi, rt_lo});
   endtask

   // Mostly saturation boundaries, otherwise any word
   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 11))
         0: return 32'h0000_0000;
         1: return 32'hffff_ffff;
         2: return 32'h0000_7fff;
         3: return 32'h0000_8000;
         4: return 32'hffff_7fff;
         5: return 32'hffff_8000;
         6: return 32'h7fff_ffff;
         7: return 32'h8000_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [63:0] pick_dword();
      return {pick_word(), pick_word()};
   endfunction

   // Hold off until every offered item has come back
   task automatic drain();
      while (instr_queue.size() != 0 || req_valid || writeback_queue.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // APB write, then read back through the same port
   task automatic csr_write(input logic [CsrAw-1:0] addr, input logic [CsrDw-1:0] data);
      logic [CsrDw-1:0] want;
      @(posedge clock);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= addr; csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      if (addr == {CSR_COP1_USABLE, 2'b00}) cop1_on = data[0];
      want = {{(CsrDw-1){1'b0}}, cop1_on};
      @(posedge clock);
      csr_psel <= 1'b1;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      check_field("cop1_usable readback", want, csr_prdata);
      @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0;
   endtask

   // Stimulus and end of run
   initial begin
      xfer_item_type it;
      hi_shadow = '{default: '0};
      lo_shadow = '{default: '0};
      fpr_shadow = '{default: '0};
      cop1_on = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: every operation, every PMFHL mode, saturation edges
      @(negedge clock);
      queue_instr(OP_MTHI, 5'd0, 5'd0, 5'd0, 64'h8000_0000_7fff_ffff, '0, '0);
      queue_instr(OP_MTLO, 5'd1, 5'd0, 5'd0, '1, '0, '0);
      queue_instr(OP_MTHI1, 5'd2, 5'd0, 5'd0, 64'h0000_0000_ffff_ffff, '0, '0);
      queue_instr(OP_MTLO1, 5'd3, 5'd0, 5'd0, 64'h7fff_ffff_8000_0000, '0, '0);
      queue_instr(OP_MFHI, 5'd31, 5'd0, 5'd0, '0, '0, '0);
      queue_instr(OP_MFLO, 5'd1, 5'd0, 5'd0, '0, '0, '0);
      queue_instr(OP_MFHI1, 5'd2, 5'd0, 5'd0, '0, '0, '0);
      queue_instr(OP_MFLO1, 5'd3, 5'd0, 5'd0, '0, '0, '0);
      queue_instr(OP_PMFHI, 5'd4, 5'd0, 5'd0, '0, '0, '0);
      queue_instr(OP_PMFLO, 5'd5, 5'd0, 5'd0, '0, '0, '0);
      for (int m = 0; m <= 4; m++)
         queue_instr(OP_PMFHL, 5'd6, 5'd0, m[RegW-1:0], '0, '0, '0);
      queue_instr(OP_PMFHL, 5'd7, 5'd0, 5'd31, '0, '0, '0);
      queue_instr(OP_PMTHL, 5'd8, 5'd0, MODE_LW,
                  64'h8000_0000_0000_7fff, 64'hffff_8000_ffff_7fff, '0);
      queue_instr(OP_PMTHL, 5'd8, 5'd0, 5'd1, '1, '1, '0);
      queue_instr(OP_PMFHL, 5'd9, 5'd0, MODE_SH, '0, '0, '0);
      queue_instr(OP_PMTHI, 5'd0, 5'd0, 5'd0, '1, '0, '0);
      queue_instr(OP_PMTLO, 5'd0, 5'd0, 5'd0, '0, '1, '0);
      queue_instr(OP_MOVN, 5'd10, 5'd0, 5'd0, '1, '0, '0);
      queue_instr(OP_MOVN, 5'd10, 5'd0, 5'd0, '1, '0, 64'h1);
      queue_instr(OP_MOVZ, 5'd11, 5'd0, 5'd0, '1, '0, '0);
      queue_instr(OP_MOVZ, 5'd11, 5'd0, 5'd0, '1, '0, 64'h8000_0000_0000_0000);
      queue_instr(OP_MTC1, 5'd31, 5'd0, 5'd0, '0, '0, 64'hffff_ffff_8000_0000);
      queue_instr(OP_MOVS, 5'd31, 5'd0, 5'd0, '0, '0, '0);
      queue_instr(OP_MFC1, 5'd0, 5'd31, 5'd0, '0, '0, '0);
      queue_instr(OP_MTC1, 5'd1, 5'd0, 5'd0, '0, '0, 64'h7fff_ffff);
      queue_instr(OP_MFC1, 5'd1, 5'd0, 5'd0, '0, '0, '0);
      queue_instr(5'd31, 5'd12, 5'd0, 5'd0, '1, '1, '1);
      drain();

      // Refused FP transfers leave the FP registers alone
      csr_write({CSR_COP1_USABLE, 2'b00}, 32'd0);
      @(negedge clock);
      queue_instr(OP_MTC1, 5'd31, 5'd0, 5'd0, '0, '0, 64'h1234);
      queue_instr(OP_MOVS, 5'd1, 5'd0, 5'd31, '0, '0, '0);
      queue_instr(OP_MFC1, 5'd31, 5'd2, 5'd0, '0, '0, '0);
      drain();

      // Random phases with alternating cop1_usable; the last one runs flat out
      for (int ph = 0; ph < 5; ph++) begin
         csr_write({CSR_COP1_USABLE, 2'b00}, (ph % 2 == 0) ? 32'd1 : 32'd0);
         idle_enable = (ph < 4);
         @(negedge clock);
         for (int n = 0; n < PhaseLen; n++) begin
            it.op = ($urandom_range(0, 99) < 4) ? OpW'($urandom_range(19, 31))
                                                : OpW'($urandom_range(0, 18));
            it.rd = RegW'($urandom_range(0, 31));
            it.rt = RegW'($urandom_range(0, 31));
            it.sa = RegW'($urandom_range(0, 31));
            if ((it.op == OP_PMFHL || it.op == OP_PMTHL) && $urandom_range(0, 4) != 0)
               it.sa = (it.op == OP_PMFHL) ? RegW'($urandom_range(0, 4)) : MODE_LW;
            it.rs_lo = pick_dword();
            it.rs_hi = pick_dword();
            it.rt_lo = ($urandom_range(0, 2) == 0) ? '0 : pick_dword();
            instr_queue.push_back(it);
         end
         drain();
      end

      repeat (10) @(posedge clock);
      $display("Checked %0d writebacks from %0d instructions across both cop1 settings,",
               retired, issued);
      $display("with random stalls on both sides and one long output hold.");
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #5_000_000;
      $display("Timed out with %0d writebacks outstanding", writeback_queue.size());
      $display("Mismatches found");
      $finish;
   end

endmodule

FILE: filelist.f
design/hlfr_pkg.sv
design/hlfr_ram.sv
design/hlfr_exec.sv
design/hilo_fpr_register_transfer_unit.sv
design/hlfr_checker.sv
bench/tb.sv
